>>> sv/dfa_word_runner_defines.svh
// assertion macros shared by the runner files
// each macro expects clk and rst_n in scope; both are off while rst_n is low
`ifndef DFA_WORD_RUNNER_DEFINES_SVH
`define DFA_WORD_RUNNER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define DFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define DFA_ASSERT(lbl, prop, msg)

`define DFA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/dfa_wr_pkg.sv
package dfa_wr_pkg;

  localparam int NUM_STATES  = 64;
  localparam int NUM_SYMBOLS = 256;

  // field widths of the stream items
  localparam int ST_W  = 6;
  localparam int SYM_W = 8;

  // final marks and table rows only exist for states the 6-bit field can name
  localparam int FM_DEPTH = (NUM_STATES < (1 << ST_W)) ? NUM_STATES : (1 << ST_W);
  localparam int FM_IW    = $clog2(FM_DEPTH);
  localparam int TT_DEPTH = FM_DEPTH * NUM_SYMBOLS;
  localparam int TT_AW    = $clog2(TT_DEPTH);

  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_CLEAR = 3'd1,
    FN_FINAL = 3'd2,
    FN_START = 3'd3,
    FN_FEED  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_READY,
    S_LOOKUP,
    S_MARK
  } fsm_t;

  typedef struct packed {
    logic            valid;
    logic [ST_W-1:0] target;
  } tt_entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [TT_AW-1:0] wr_addr;
    tt_entry_t        wr_data;
    logic             rd_en;
    logic [TT_AW-1:0] rd_addr;
  } tt_req_t;

endpackage

>>> sv/dfa_wr_table.sv
`include "dfa_word_runner_defines.svh"

module dfa_wr_table
  import dfa_wr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tt_req_t   req,
  output tt_entry_t rd_data,
  output logic      busy
);

  tt_entry_t        tt_mem_r [TT_DEPTH];
  tt_entry_t        rd_data_r;
  logic             clr_active_r, clr_active_nxt;
  logic [TT_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic             mem_we;
  logic [TT_AW-1:0] mem_waddr;
  tt_entry_t        mem_wdata;

  // clearing sweep, one entry per cycle after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      if (clr_addr_r == TT_AW'(TT_DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + TT_AW'(1);
      end
    end
  end

  always_comb begin
    mem_we    = clr_active_r | req.wr_en;
    mem_waddr = clr_active_r ? clr_addr_r : req.wr_addr;
    mem_wdata = clr_active_r ? '0 : req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tt_mem_r[mem_waddr] <= mem_wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= tt_mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

  `DFA_ASSERT(a_clear_blocks_port, clr_active_r |-> !req.wr_en && !req.rd_en, "access while clearing")
  `DFA_ASSERT(a_clear_full_sweep, $fell(clr_active_r) |-> $past(clr_addr_r) == TT_AW'(TT_DEPTH - 1), "clearing ended early")
  `DFA_ASSERT(a_single_access, !(req.wr_en && req.rd_en), "read and write in one cycle")

endmodule

>>> sv/dfa_word_runner.sv
// dfa_word_runner: runs words through a deterministic automaton held in a transition
// memory of 64 states by 256 symbols, with the final marks in a second small memory.
// each input transaction carries a function in in_tuser: write or clear one transition,
// set a state's final mark, start a word at a state, or feed one symbol (in_tlast marks
// the word's last symbol). every input transaction gives exactly one output transaction
// with the current state, the stuck flag and, on a start or on the last symbol, whether
// the word is accepted. table and mark transactions are answered at accept; a start
// waits for the registered read of the final-mark memory; a feed waits for the registered
// read of the single-port transition memory, whose address needs the state left by the
// previous symbol, then the registered final-mark read of the new state. after reset the
// transition memory is swept clear, one entry a cycle, over all 16384 entries (the 64
// final marks are swept alongside), and in_tready stays low until both sweeps are done.
// a result waiting on out_tready holds back the next input transaction.
`include "dfa_word_runner_defines.svh"

module dfa_word_runner
  import dfa_wr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // from_state[5:0], symbol[13:6], to_state[19:14],
                                 // final_mark[20], zero fill[23:21]
  input  logic [2:0]  in_tuser,  // func[2:0]
  input  logic        in_tlast,  // word_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata  // cur_state[5:0], stuck[6], accepting[7]
);

  // field unpacking
  logic [ST_W-1:0]  in_from;
  logic [SYM_W-1:0] in_sym;
  logic [ST_W-1:0]  in_to;
  logic             in_final;
  func_t            fn;

  assign in_from  = in_tdata[5:0];
  assign in_sym   = in_tdata[13:6];
  assign in_to    = in_tdata[19:14];
  assign in_final = in_tdata[20];
  assign fn       = func_t'(in_tuser);

  // helpers
  function automatic logic st_ok(input logic [ST_W-1:0] s);
    return 32'(s) < 32'(NUM_STATES);
  endfunction

  function automatic logic sym_ok_f(input logic [SYM_W-1:0] y);
    return 32'(y) < 32'(NUM_SYMBOLS);
  endfunction

  function automatic logic [FM_IW-1:0] fm_idx(input logic [ST_W-1:0] s);
    return s[FM_IW-1:0];
  endfunction

  // row of the state times the row length, plus the symbol
  function automatic logic [TT_AW-1:0] tt_addr(input logic [ST_W-1:0] s,
                                               input logic [SYM_W-1:0] y);
    return TT_AW'(TT_AW'(fm_idx(s)) * TT_AW'(NUM_SYMBOLS) + TT_AW'(y));
  endfunction

  // state and registers
  fsm_t            fsm_r, fsm_nxt;
  logic [ST_W-1:0] cur_state_r, cur_state_nxt;
  logic            stuck_r, stuck_nxt;
  logic            judge_r;    // acceptance is reported for the transaction in flight
  logic            sym_ok_r;   // its symbol lies inside the table
  logic            out_valid_r, out_valid_nxt;
  logic [ST_W-1:0] out_state_r;
  logic            out_stuck_r;
  logic            out_acc_r;

  // final-mark memory, swept clear after reset
  logic             fm_mem_r [FM_DEPTH];
  logic             fm_rd_r;
  logic             fm_clr_active_r, fm_clr_active_nxt;
  logic [FM_IW-1:0] fm_clr_addr_r, fm_clr_addr_nxt;
  logic             fm_mem_we;
  logic [FM_IW-1:0] fm_waddr;
  logic             fm_wdata;
  logic             fm_re;
  logic [FM_IW-1:0] fm_raddr;

  // transition memory
  tt_req_t   tt_req;
  tt_entry_t tt_rd_data;
  logic      tt_busy;

  dfa_wr_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tt_req),
    .rd_data (tt_rd_data),
    .busy    (tt_busy)
  );

  logic accept;
  logic lookup;
  logic mark_stage;
  logic one_cycle;
  logic from_ok, to_ok, sym_ok;
  logic fm_we;

  // state and flag left by the transaction being accepted
  logic [ST_W-1:0] acc_state;
  logic            acc_stuck;

  // outcome of a feed once its table entry is back
  logic [ST_W-1:0] lk_state;
  logic            lk_stuck;

  // acceptance once the final mark is back
  logic            mk_acc;

  assign accept    = in_tvalid && in_tready;
  assign from_ok   = st_ok(in_from);
  assign to_ok     = st_ok(in_to);
  assign sym_ok    = sym_ok_f(in_sym);
  assign one_cycle = accept && fn != FN_FEED && fn != FN_START;

  // next state of the sequencer
  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      S_CLEAR:  if (!tt_busy && !fm_clr_active_r) fsm_nxt = S_READY;
      S_READY: begin
        if (accept && fn == FN_FEED) begin
          fsm_nxt = S_LOOKUP;
        end else if (accept && fn == FN_START) begin
          fsm_nxt = S_MARK;
        end
      end
      S_LOOKUP: fsm_nxt = S_MARK;
      S_MARK:   fsm_nxt = S_READY;
      default:  fsm_nxt = S_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    lookup     = 1'b0;
    mark_stage = 1'b0;
    unique case (fsm_r)
      S_CLEAR:  in_tready = 1'b0;
      S_READY:  in_tready = !out_valid_r || out_tready;
      S_LOOKUP: lookup = 1'b1;
      S_MARK:   mark_stage = 1'b1;
      default:  in_tready = 1'b0;
    endcase
  end

  // function decode: table requests, mark writes and start state
  always_comb begin
    tt_req         = '0;
    tt_req.wr_addr = tt_addr(in_from, in_sym);
    tt_req.rd_addr = tt_addr(cur_state_r, in_sym);
    fm_we          = 1'b0;
    acc_state      = cur_state_r;
    acc_stuck      = stuck_r;
    unique case (fn)
      FN_WRITE: begin
        tt_req.wr_en          = accept && from_ok && sym_ok && to_ok;
        tt_req.wr_data.valid  = 1'b1;
        tt_req.wr_data.target = in_to;
      end
      FN_CLEAR: begin
        tt_req.wr_en = accept && from_ok && sym_ok;
      end
      FN_FINAL: begin
        fm_we = accept && from_ok;
      end
      FN_START: begin
        // an out-of-range start state leaves the word stuck at once
        acc_state = in_from;
        acc_stuck = !from_ok;
      end
      FN_FEED: begin
        tt_req.rd_en = accept;
      end
      default: begin
      end
    endcase
  end

  // feed completion; a stuck word keeps its state and flag
  always_comb begin
    lk_state = cur_state_r;
    lk_stuck = stuck_r;
    if (!stuck_r) begin
      if (sym_ok_r && tt_rd_data.valid) begin
        lk_state = tt_rd_data.target;
      end else begin
        lk_stuck = 1'b1;
      end
    end
  end

  // state and flag are already settled when the mark comes back
  assign mk_acc = judge_r && !stuck_r && st_ok(cur_state_r) && fm_rd_r;

  always_comb begin
    cur_state_nxt = cur_state_r;
    stuck_nxt     = stuck_r;
    if (lookup) begin
      cur_state_nxt = lk_state;
      stuck_nxt     = lk_stuck;
    end else if (accept) begin
      cur_state_nxt = acc_state;
      stuck_nxt     = acc_stuck;
    end
  end

  // final-mark sweep, one entry per cycle after reset
  always_comb begin
    fm_clr_active_nxt = fm_clr_active_r;
    fm_clr_addr_nxt   = fm_clr_addr_r;
    if (fm_clr_active_r) begin
      if (fm_clr_addr_r == FM_IW'(FM_DEPTH - 1)) begin
        fm_clr_active_nxt = 1'b0;
      end else begin
        fm_clr_addr_nxt = fm_clr_addr_r + FM_IW'(1);
      end
    end
  end

  // final-mark port: start reads its own state, a lookup reads the new state
  always_comb begin
    fm_mem_we = fm_clr_active_r | fm_we;
    fm_waddr  = fm_clr_active_r ? fm_clr_addr_r : fm_idx(in_from);
    fm_wdata  = fm_clr_active_r ? 1'b0 : in_final;
    fm_re     = lookup || (accept && fn == FN_START);
    fm_raddr  = lookup ? fm_idx(lk_state) : fm_idx(in_from);
  end

  // result slot: filled at accept for functions other than start and feed, after the mark read otherwise
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (mark_stage || one_cycle) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r           <= S_CLEAR;
      cur_state_r     <= '0;
      stuck_r         <= 1'b0;
      out_valid_r     <= 1'b0;
      fm_clr_active_r <= 1'b1;
      fm_clr_addr_r   <= '0;
    end else begin
      fsm_r           <= fsm_nxt;
      cur_state_r     <= cur_state_nxt;
      stuck_r         <= stuck_nxt;
      out_valid_r     <= out_valid_nxt;
      fm_clr_active_r <= fm_clr_active_nxt;
      fm_clr_addr_r   <= fm_clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fm_mem_we) begin
      fm_mem_r[fm_waddr] <= fm_wdata;
    end
    if (fm_re) begin
      fm_rd_r <= fm_mem_r[fm_raddr];
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      judge_r  <= in_tlast || fn == FN_START;
      sym_ok_r <= sym_ok;
    end
    if (mark_stage) begin
      out_state_r <= cur_state_r;
      out_stuck_r <= stuck_r;
      out_acc_r   <= mk_acc;
    end else if (one_cycle) begin
      out_state_r <= acc_state;
      out_stuck_r <= acc_stuck;
      out_acc_r   <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_acc_r, out_stuck_r, out_state_r};

  `DFA_ASSERT(a_no_accept_clearing, in_tready |-> !tt_busy && !fm_clr_active_r, "input taken during clearing")
  `DFA_ASSERT(a_lookup_after_feed, fsm_r == S_LOOKUP |-> $past(accept && fn == FN_FEED), "lookup without a feed")
  `DFA_ASSERT(a_lookup_quiet_table, fsm_r == S_LOOKUP |-> !tt_req.wr_en && !tt_req.rd_en, "table access during lookup")
  `DFA_ASSERT(a_mark_has_source, fsm_r == S_MARK |-> $past(lookup || (accept && fn == FN_START)), "mark read without a source")
  `DFA_ASSERT_NEXT(a_quick_result, one_cycle, out_valid_r, "one-cycle result missing")

endmodule
